>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear-probe hash table
// Slot states, op kinds, status codes and field widths.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
  localparam int SIZE_BITS    = 9;
  localparam int CNT_BITS     = IDX_BITS + 1;

  typedef logic [1:0]              kind_t;
  typedef logic [2:0]              status_t;
  typedef logic [1:0]              slot_state_t;
  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [IDX_BITS-1:0]     idx_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [SIZE_BITS-1:0]    size_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  localparam slot_state_t SL_EMPTY   = 2'd0;
  localparam slot_state_t SL_USED    = 2'd1;
  localparam slot_state_t SL_DELETED = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FOUND     = 3'd1;
  localparam status_t ST_RECORDED  = 3'd2;
  localparam status_t ST_DELETED   = 3'd3;
  localparam status_t ST_DEL_MISS  = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

endpackage

>>> design/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// Insert / lookup-with-record / delete over a 256-slot on-chip table.
// ----------------------------------------------------------------------------
// One word in, one result word out. After reset a clearing pass over all
// TABLE_DEPTH (256) slots marks every slot empty; no word is taken during
// it. Per word: the home slot is key mod the effective size esize, found by
// a restoring divider at one quotient bit per cycle. Probing then reads the
// slot memory one slot at a time, each probe step a READ state (address set,
// registered read) then an EVAL state (data back), stopping at a hit (a free
// slot for insert), an empty slot, or esize probes. A WRITE state then
// updates the slot for an insert, recorded lookup or delete hit. Probes run
// from 1 to esize. Kind 3 is answered directly. The result sits in an
// output register; the next word is held off while busy or while a stalled
// result waits. table_size is written only while idle or clearing.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lpht_pkg::kind_t        kind,
  input  lpht_pkg::key_t         key,
  input  lpht_pkg::payload_t     payload,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lpht_pkg::status_t      status,
  output logic [7:0]             slot,
  output logic [8:0]             probes,
  output logic [31:0]            found_payload,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lpht_pkg::size_t        cfg_data
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int DIV_CNT_BITS = $clog2(KEY_BITS + 1);

  typedef struct packed {
    slot_state_t st;
    key_t        k;
    payload_t    p;
    cnt_t        pc;
  } entry_t;

  // slot memory, one synchronous port each for read and write
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [2:0] state;
  size_t      table_size;
  cnt_t       esize;
  kind_t      op;
  key_t       op_key;
  payload_t   op_pay;
  key_t       quo;       // dividend shifting out
  logic [SIZE_BITS:0] rem;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  idx_t       pos;
  cnt_t       n;
  logic       have_free;
  idx_t       free_pos;
  cnt_t       free_n;
  idx_t       clr_idx;

  status_t    r_status;
  idx_t       r_slot;
  cnt_t       r_probes;
  payload_t   r_pay;

  // effective size, clamped to [2, TABLE_DEPTH]
  always_comb begin
    if (table_size < SIZE_BITS'(2)) begin
      esize = CNT_BITS'(2);
    end else if (table_size > SIZE_BITS'(TABLE_DEPTH)) begin
      esize = CNT_BITS'(TABLE_DEPTH);
    end else begin
      esize = CNT_BITS'(table_size);
    end
  end

  logic busy;
  assign busy      = (state != S_IDLE);
  assign in_stall  = busy || (out_valid && out_stall);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);

  logic accept;
  assign accept = in_valid && !in_stall;

  logic [SIZE_BITS:0] rem_sh;
  logic [SIZE_BITS:0] rem_sub;
  assign rem_sh  = {rem[SIZE_BITS-1:0], quo[KEY_BITS-1]};
  assign rem_sub = rem_sh - (SIZE_BITS+1)'(esize);

  logic hit, is_free, stop_empty, last_probe;
  assign hit        = (rd_data.st == SL_USED) && (rd_data.k == op_key);
  assign is_free    = (rd_data.st != SL_USED);
  assign stop_empty = (rd_data.st == SL_EMPTY);
  assign last_probe = (n == esize);

  idx_t pos_inc;
  assign pos_inc = (CNT_BITS'(pos) + CNT_BITS'(1) == esize) ? '0 : pos + idx_t'(1);

  always_comb begin
    rd_addr = pos;
    wr_en   = 1'b0;
    wr_addr = free_pos;
    wr_data = '{st: SL_USED, k: op_key, p: op_pay, pc: free_n};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = '{st: SL_EMPTY, k: '0, p: '0, pc: '0};
    end else if (state == S_WRITE) begin
      wr_en = 1'b1;
      if (op == KIND_DELETE) begin
        wr_addr = pos;
        wr_data = '{st: SL_DELETED, k: op_key, p: r_pay, pc: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      table_size <= SIZE_BITS'(TABLE_DEPTH);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + idx_t'(1);
          if (clr_idx == idx_t'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op      <= kind;
            op_key  <= key;
            op_pay  <= payload;
            quo     <= key;
            rem     <= '0;
            div_cnt <= '0;
            if (kind == KIND_NONE) begin
              r_status <= ST_DEL_MISS;
              r_slot   <= '0;
              r_probes <= '0;
              r_pay    <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo <= {quo[KEY_BITS-2:0], 1'b0};
          rem <= rem_sub[SIZE_BITS] ? rem_sh : rem_sub;
          div_cnt <= div_cnt + DIV_CNT_BITS'(1);
          if (div_cnt == DIV_CNT_BITS'(KEY_BITS - 1)) begin
            pos       <= rem_sub[SIZE_BITS] ? rem_sh[IDX_BITS-1:0] : rem_sub[IDX_BITS-1:0];
            n         <= CNT_BITS'(1);
            have_free <= 1'b0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (op == KIND_INSERT) begin
            if (is_free) begin
              free_pos <= pos;
              free_n   <= n;
              r_status <= ST_INSERTED;
              r_slot   <= pos;
              r_probes <= n;
              r_pay    <= '0;
              state    <= S_WRITE;
            end else if (last_probe) begin
              r_status <= ST_FULL;
              r_slot <= '0; r_probes <= '0; r_pay <= '0;
              state    <= S_EMIT;
            end else begin
              pos <= pos_inc; n <= n + CNT_BITS'(1); state <= S_READ;
            end
          end else if (hit) begin
            r_slot   <= pos;
            r_probes <= rd_data.pc;
            r_pay    <= rd_data.p;
            if (op == KIND_LOOKUP) begin
              r_status <= ST_FOUND;
              state    <= S_EMIT;
            end else begin
              r_status <= ST_DELETED;
              state    <= S_WRITE;
            end
          end else begin
            logic hf;
            idx_t fp;
            cnt_t fn;
            hf = have_free;
            fp = free_pos;
            fn = free_n;
            if (is_free && !have_free) begin
              hf = 1'b1; fp = pos; fn = n;
            end
            have_free <= hf;
            free_pos  <= fp;
            free_n    <= fn;
            if (stop_empty || last_probe) begin
              r_pay <= '0;
              if (op == KIND_DELETE) begin
                r_status <= ST_DEL_MISS;
                r_slot <= '0; r_probes <= '0;
                state <= S_EMIT;
              end else if (!hf) begin
                r_status <= ST_FULL;
                r_slot <= '0; r_probes <= '0;
                state <= S_EMIT;
              end else begin
                r_status <= ST_RECORDED;
                r_slot <= fp; r_probes <= fn;
                state <= S_WRITE;
              end
            end else begin
              pos <= pos_inc; n <= n + CNT_BITS'(1); state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded only when empty or being taken (EMIT waits on
  // in_stall gating, so the previous word is always gone by now)
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      status        <= r_status;
      slot          <= 8'(r_slot);
      probes        <= 9'(r_probes);
      found_payload <= 32'(r_pay);
    end
  end

  // no word taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("word taken during clear");

  // probe count never passes table size
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (n <= esize && n != '0))
    else $error("probe count out of range");

  // a result is only loaded once the previous one has left
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (!out_valid || !out_stall || $past(state) != S_IDLE))
    else $error("output overrun");

endmodule

>>> verif/tb_linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_unit: self-checking bench for the hash table
// Drives insert / lookup / delete / unused-kind words with random idle and
// stall, keeps its own model of the slot table and checks every result word field by field.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  typedef struct packed {
    status_t  st;
    idx_t     sl;
    cnt_t     pc;
    payload_t fp;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input channel.
  logic     in_valid = 1'b0;
  logic     in_stall;
  kind_t    kind = KIND_INSERT;
  key_t     key = '0;
  payload_t payload = '0;

  // Result channel.
  logic       out_valid;
  logic       out_stall = 1'b0;
  status_t    status;
  logic [7:0] slot;
  logic [8:0] probes;
  logic [31:0] found_payload;

  // Config channel.
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  size_t cfg_data = '0;

  int errors = 0;

  // Idle knobs: percent of cycles the sender idles / receiver stalls.
  int send_idle_pct = 11;
  int recv_stall_pct = 11;
  int hold_off_cycles = 0;

  // Shadow of the slot table.
  slot_state_t tbl_state [TABLE_DEPTH];
  key_t        tbl_key   [TABLE_DEPTH];
  payload_t    tbl_pay   [TABLE_DEPTH];
  cnt_t        tbl_pc    [TABLE_DEPTH];
  size_t       size_reg;

  answer_t pending_answers[$];

  linear_probe_hash_table_unit dut (
    .clk, .rst, .in_valid, .in_stall, .kind, .key, .payload,
    .out_valid, .out_stall, .status, .slot, .probes, .found_payload,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predict one word's answer and update the shadow table.
  function automatic answer_t hash_table_apply(kind_t k, key_t kv, payload_t pv);
    int      sz;
    int      pos;
    bit      have_free;
    int      free_pos;
    int      free_n;
    answer_t a;
    sz = (size_reg < 2) ? 2 : (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
    pos = kv % sz;
    have_free = 0;
    free_pos = 0;
    free_n = 0;
    a = '0;
    if (k == KIND_NONE) begin
      a.st = ST_DEL_MISS;
      return a;
    end
    for (int n = 1; n <= sz; n++) begin
      if (k == KIND_INSERT) begin
        if (tbl_state[pos] != SL_USED) begin
          have_free = 1; free_pos = pos; free_n = n;
          break;
        end
      end else begin
        if (tbl_state[pos] == SL_USED && tbl_key[pos] == kv) begin
          a.sl = idx_t'(pos);
          a.pc = tbl_pc[pos];
          a.fp = tbl_pay[pos];
          if (k == KIND_LOOKUP) begin
            a.st = ST_FOUND;
          end else begin
            a.st = ST_DELETED;
            tbl_state[pos] = SL_DELETED;
            tbl_pc[pos] = '0;
          end
          return a;
        end
        if (tbl_state[pos] != SL_USED && !have_free) begin
          have_free = 1; free_pos = pos; free_n = n;
        end
        if (tbl_state[pos] == SL_EMPTY) break;
      end
      pos = (pos + 1 == sz) ? 0 : pos + 1;
    end
    if (k == KIND_DELETE) begin
      a.st = ST_DEL_MISS;
      return a;
    end
    if (!have_free) begin
      a.st = ST_FULL;
      return a;
    end
    tbl_state[free_pos] = SL_USED;
    tbl_key[free_pos] = kv;
    tbl_pay[free_pos] = pv;
    tbl_pc[free_pos] = cnt_t'(free_n);
    a.st = (k == KIND_INSERT) ? ST_INSERTED : ST_RECORDED;
    a.sl = idx_t'(free_pos);
    a.pc = cnt_t'(free_n);
    return a;
  endfunction

  // Send one word; the prediction is queued when the word is taken.
  // Valid drops only on idle cycles, so back-to-back words keep it high.
  task automatic send_word(kind_t k, key_t kv, payload_t pv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    key <= kv;
    payload <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(hash_table_apply(k, kv, pv));
  endtask

  // Wait for all answers, let the block settle, then write table_size.
  task automatic set_table_size(size_t v);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  // Receiver: random stall plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Checker: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected: status %0d", status);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (status !== exp_a.st) begin
          $error("status: expected %0d, got %0d", exp_a.st, status); errors++;
        end
        if (slot !== exp_a.sl) begin
          $error("slot: expected %0d, got %0d", exp_a.sl, slot); errors++;
        end
        if (probes !== exp_a.pc) begin
          $error("probes: expected %0d, got %0d", exp_a.pc, probes); errors++;
        end
        if (found_payload !== exp_a.fp) begin
          $error("found_payload: expected %h, got %h", exp_a.fp, found_payload);
          errors++;
        end
      end
    end
  end

  // Extremes of the fields, every kind, full table, wrap and tombstones.
  task automatic test_directed();
    set_table_size(9'd4);
    send_word(KIND_DELETE, 16'd5, 32'h0);          // delete miss on empty table
    send_word(KIND_INSERT, 16'd0, 32'h0);
    send_word(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);  // home slot 3
    send_word(KIND_INSERT, 16'd7, 32'hA5A5_5A5A);     // wraps to slot 1
    send_word(KIND_LOOKUP, 16'd7, 32'h0);          // hit after wrap
    send_word(KIND_INSERT, 16'd4, 32'h1234_5678);     // fills last slot
    send_word(KIND_INSERT, 16'd8, 32'h1);          // table full
    send_word(KIND_LOOKUP, 16'd12, 32'h2);         // miss on full table
    send_word(KIND_DELETE, 16'hFFFF, 32'h0);       // tombstone
    send_word(KIND_LOOKUP, 16'd4, 32'h0);          // hit at slot 2
    send_word(KIND_LOOKUP, 16'd99, 32'h5555_AAAA);    // records at tombstone
    send_word(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF); // unused kind
    send_word(KIND_DELETE, 16'd0, 32'h0);
    set_table_size(9'd0);                          // acts as 2
    send_word(KIND_LOOKUP, 16'd1, 32'h7);
    send_word(KIND_INSERT, 16'd3, 32'h8);
    set_table_size(9'd511);                        // acts as 256
    send_word(KIND_INSERT, 16'd255, 32'h9);
    send_word(KIND_INSERT, 16'd511, 32'hA);        // wraps past 0, lands in slot 4
    send_word(KIND_LOOKUP, 16'd511, 32'h0);
    send_word(KIND_DELETE, 16'd255, 32'h0);
  endtask

  // Random mix, mostly keys from a small pool so hits and tombstones happen.
  task automatic test_random(int count, int key_pool);
    kind_t    k;
    key_t     kv;
    payload_t pv;
    for (int i = 0; i < count; i++) begin
      k = kind_t'($urandom_range(99) < 3 ? KIND_NONE : $urandom_range(2));
      kv = ($urandom_range(9) == 0) ? key_t'($urandom) : key_t'($urandom_range(key_pool));
      pv = $urandom;
      send_word(k, kv, pv);
    end
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_off_cycles = 300;
    send_idle_pct = 0;
    test_random(12, 40);
    send_idle_pct = 11;
  endtask

  initial begin
    foreach (tbl_state[i]) begin
      tbl_state[i] = SL_EMPTY;
      tbl_key[i] = '0;
      tbl_pay[i] = '0;
      tbl_pc[i] = '0;
    end
    size_reg = 9'd256;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    set_table_size(9'd256);
    test_random(200, 2000);
    set_table_size(9'd17);
    test_random(150, 60);
    test_backpressure();
    set_table_size(9'd2);
    test_random(60, 8);
    // No idling at all for a stretch.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_table_size(9'd64);
    test_random(150, 200);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    set_table_size(9'd200);
    test_random(180, 65535);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/lpht_pkg.sv
design/linear_probe_hash_table_unit.sv
verif/tb_linear_probe_hash_table_unit.sv
